// File: rtl/v3alu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared types, sizes and helpers for the three-component fixed-point ALU.
// ----------------------------------------------------------------------------
package v3alu_pkg;

    localparam int COMP_W  = 32;                 // component width
    localparam int FRAC_W  = 16;                 // fraction bits
    localparam int NLANE   = 3;
    localparam int PROD_W  = 2 * COMP_W;         // one full product
    localparam int SQ_W    = 2 * COMP_W;         // sum of three squared magnitudes
    localparam int ROOT_W  = COMP_W;             // integer root width
    localparam int LEN_W   = ROOT_W + 1;         // rounded root
    localparam int QW      = FRAC_W + 1;         // quotient bits, normalized magnitude <= 1.0
    localparam int NUM_W   = COMP_W + FRAC_W;    // dividend width
    localparam int SAT_W   = PROD_W + 4;         // widest value that gets clamped
    localparam int SQRT_LAT  = ROOT_W + 1;
    localparam int DIV_LAT   = QW + 1;
    localparam int EARLY_DLY = SQRT_LAT - 1 + DIV_LAT;
    localparam int PIPE_DEPTH = 2 + SQRT_LAT + DIV_LAT + 1;

    localparam logic [COMP_W-1:0] CMAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic [COMP_W-1:0] CMIN = {1'b1, {(COMP_W-1){1'b0}}};
    localparam logic signed [SAT_W-1:0] RND_HALF = SAT_W'(1) <<< (FRAC_W - 1);

    typedef enum logic [2:0] {
        FN_ADD    = 3'd0,
        FN_SUB    = 3'd1,
        FN_NEG    = 3'd2,
        FN_DOT    = 3'd3,
        FN_CROSS  = 3'd4,
        FN_EQUAL  = 3'd5,
        FN_LENGTH = 3'd6,
        FN_NORM   = 3'd7
    } t_func;

    typedef struct packed {
        logic signed [PROD_W-1:0] pdot;
        logic signed [PROD_W-1:0] pc1;
        logic signed [PROD_W-1:0] pc2;
        logic        [SQ_W-1:0]   sq;
        logic signed [COMP_W+1:0] lin;
        logic        [COMP_W-1:0] mag;
        logic                     neg;
        logic                     eq;
        logic                     nz;
    } t_lane;

    typedef struct packed {
        logic [NLANE-1:0][COMP_W-1:0] mag;
        logic [NLANE-1:0]             neg;
    } t_ntag;

    typedef struct packed {
        t_func                        func;
        logic [NLANE-1:0][COMP_W-1:0] res;
        logic                         sat;
        logic                         eq;
        logic                         nz;
    } t_early;

    typedef struct packed {
        logic [COMP_W-1:0] val;
        logic              flag;
    } t_sat;

    function automatic t_sat sat_c(input logic signed [SAT_W-1:0] v);
        t_sat r;
        if ((&v[SAT_W-1:COMP_W-1]) || ~(|v[SAT_W-1:COMP_W-1])) begin
            r.val  = v[COMP_W-1:0];
            r.flag = 1'b0;
        end else begin
            r.val  = v[SAT_W-1] ? CMIN : CMAX;
            r.flag = 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/v3alu_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// v3alu_lane
// One component lane: products, squared magnitude and linear result.
// ----------------------------------------------------------------------------
module v3alu_lane
    import v3alu_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_en,
    input  wire t_func              i_func,
    input  wire logic signed [COMP_W-1:0] i_a_i,
    input  wire logic signed [COMP_W-1:0] i_a_j,
    input  wire logic signed [COMP_W-1:0] i_a_k,
    input  wire logic signed [COMP_W-1:0] i_b_i,
    input  wire logic signed [COMP_W-1:0] i_b_j,
    input  wire logic signed [COMP_W-1:0] i_b_k,
    output t_lane                   o_lane
);

    t_lane                     r_lane;
    logic [COMP_W-1:0]         w_mag;
    logic signed [COMP_W+1:0]  w_lin;

    assign w_mag = i_a_i[COMP_W-1] ? (~i_a_i + COMP_W'(1)) : i_a_i;

    always_comb begin
        case (i_func)
            FN_ADD:  w_lin = (COMP_W+2)'(i_a_i) + (COMP_W+2)'(i_b_i);
            FN_SUB:  w_lin = (COMP_W+2)'(i_a_i) - (COMP_W+2)'(i_b_i);
            default: w_lin = (COMP_W+2)'(0) - (COMP_W+2)'(i_a_i);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane.pdot <= i_a_i * i_b_i;
            r_lane.pc1  <= i_a_j * i_b_k;
            r_lane.pc2  <= i_a_k * i_b_j;
            r_lane.sq   <= SQ_W'(w_mag) * SQ_W'(w_mag);
            r_lane.lin  <= w_lin;
            r_lane.mag  <= w_mag;
            r_lane.neg  <= i_a_i[COMP_W-1];
            r_lane.eq   <= (i_a_i == i_b_i);
            r_lane.nz   <= |i_a_i;
        end
    end

    assign o_lane = r_lane;

endmodule
`default_nettype wire

// File: rtl/v3alu_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// v3alu_merge
// Combine lane results: dot and cross sums, sum of squares, early results.
// ----------------------------------------------------------------------------
module v3alu_merge
    import v3alu_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_en,
    input  wire t_func       i_func,
    input  wire t_lane       i_lane [NLANE],
    output logic [SQ_W-1:0]  o_sqsum,
    output t_ntag            o_tag,
    output t_early           o_early
);

    t_func                      r_func;
    logic signed [PROD_W+1:0]   r_dot;
    logic signed [PROD_W:0]     r_cr  [NLANE];
    logic signed [COMP_W+1:0]   r_lin [NLANE];
    logic [SQ_W-1:0]            r_sq;
    logic                       r_eq;
    logic                       r_nz;
    t_ntag                      r_tag;
    t_early                     r_early;
    t_early                     n_early;
    t_sat                       w_s   [NLANE];
    t_sat                       w_dot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_func <= i_func;
            r_dot  <= (PROD_W+2)'(i_lane[0].pdot) + (PROD_W+2)'(i_lane[1].pdot)
                    + (PROD_W+2)'(i_lane[2].pdot);
            r_sq   <= i_lane[0].sq + i_lane[1].sq + i_lane[2].sq;
            r_eq   <= i_lane[0].eq & i_lane[1].eq & i_lane[2].eq;
            r_nz   <= i_lane[0].nz | i_lane[1].nz | i_lane[2].nz;
            for (int i = 0; i < NLANE; i++) begin
                r_cr[i]      <= (PROD_W+1)'(i_lane[i].pc1) - (PROD_W+1)'(i_lane[i].pc2);
                r_lin[i]     <= i_lane[i].lin;
                r_tag.mag[i] <= i_lane[i].mag;
                r_tag.neg[i] <= i_lane[i].neg;
            end
        end
    end

    assign w_dot = sat_c((SAT_W'(r_dot) + RND_HALF) >>> FRAC_W);

    always_comb begin
        n_early.func = r_func;
        n_early.res  = '0;
        n_early.sat  = 1'b0;
        n_early.eq   = 1'b0;
        n_early.nz   = r_nz;
        for (int i = 0; i < NLANE; i++) begin
            w_s[i] = sat_c(SAT_W'(r_lin[i]));
        end
        case (r_func) inside
            FN_ADD, FN_SUB, FN_NEG: begin
                for (int i = 0; i < NLANE; i++) begin
                    n_early.res[i] = w_s[i].val;
                end
                n_early.sat = w_s[0].flag | w_s[1].flag | w_s[2].flag;
            end
            FN_DOT: begin
                n_early.res[0] = w_dot.val;
                n_early.sat    = w_dot.flag;
            end
            FN_CROSS: begin
                for (int i = 0; i < NLANE; i++) begin
                    w_s[i] = sat_c((SAT_W'(r_cr[i]) + RND_HALF) >>> FRAC_W);
                    n_early.res[i] = w_s[i].val;
                end
                n_early.sat = w_s[0].flag | w_s[1].flag | w_s[2].flag;
            end
            FN_EQUAL: n_early.eq = r_eq;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_early <= n_early;
        end
    end

    assign o_sqsum = r_sq;
    assign o_tag   = r_tag;
    assign o_early = r_early;

endmodule
`default_nettype wire

// File: rtl/v3alu_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// v3alu_sqrt
// Pipelined integer square root, one root bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module v3alu_sqrt
    import v3alu_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_en,
    input  wire [SQ_W-1:0]   i_sum,
    input  wire t_ntag       i_tag,
    output logic [LEN_W-1:0] o_len,
    output t_ntag            o_tag
);

    logic [SQ_W-1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    t_ntag             r_tag  [ROOT_W];
    logic [LEN_W-1:0]  r_len;
    t_ntag             r_tag_out;

    for (genvar s = 0; s < ROOT_W; s++) begin : g_step
        localparam int B = ROOT_W - 1 - s;
        logic [SQ_W-1:0]   w_rem;
        logic [ROOT_W-1:0] w_root;
        t_ntag             w_tag;
        logic [SQ_W+1:0]   w_trial;
        logic              w_ge;
        if (s == 0) begin : g_first
            assign w_rem  = i_sum;
            assign w_root = '0;
            assign w_tag  = i_tag;
        end else begin : g_next
            assign w_rem  = r_rem[s-1];
            assign w_root = r_root[s-1];
            assign w_tag  = r_tag[s-1];
        end
        // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
        assign w_trial = ((SQ_W+2)'(w_root) << (B + 1)) + ((SQ_W+2)'(1) << (2 * B));
        assign w_ge    = ({2'b00, w_rem} >= w_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? (w_rem - w_trial[SQ_W-1:0]) : w_rem;
                r_root[s] <= w_ge ? (w_root | (ROOT_W'(1) << B)) : w_root;
                r_tag[s]  <= w_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len     <= LEN_W'(r_root[ROOT_W-1])
                       + LEN_W'(r_rem[ROOT_W-1] > SQ_W'(r_root[ROOT_W-1]));
            r_tag_out <= r_tag[ROOT_W-1];
        end
    end

    assign o_len = r_len;
    assign o_tag = r_tag_out;

endmodule
`default_nettype wire

// File: rtl/v3alu_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// v3alu_div
// Pipelined restoring divider for one lane: magnitude * 2^FRAC_W / length,
// rounded to nearest with halves away from zero.
// ----------------------------------------------------------------------------
module v3alu_div
    import v3alu_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_en,
    input  wire [COMP_W-1:0] i_mag,
    input  wire              i_neg,
    input  wire [LEN_W-1:0]  i_len,
    output logic [QW:0]      o_q,
    output logic             o_neg
);

    localparam int CMP_W = LEN_W + QW;

    logic [NUM_W-1:0] r_rem [QW];
    logic [QW-1:0]    r_q   [QW];
    logic [LEN_W-1:0] r_d   [QW];
    logic             r_neg [QW];
    logic [QW:0]      r_q_out;
    logic             r_neg_out;

    for (genvar s = 0; s < QW; s++) begin : g_step
        localparam int K = QW - 1 - s;
        logic [NUM_W-1:0] w_rem;
        logic [QW-1:0]    w_q;
        logic [LEN_W-1:0] w_d;
        logic             w_neg;
        logic [CMP_W-1:0] w_trial;
        logic             w_ge;
        if (s == 0) begin : g_first
            assign w_rem = {i_mag, {FRAC_W{1'b0}}};
            assign w_q   = '0;
            assign w_d   = i_len;
            assign w_neg = i_neg;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_q   = r_q[s-1];
            assign w_d   = r_d[s-1];
            assign w_neg = r_neg[s-1];
        end
        assign w_trial = CMP_W'(w_d) << K;
        assign w_ge    = (CMP_W'(w_rem) >= w_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? (w_rem - w_trial[NUM_W-1:0]) : w_rem;
                r_q[s]   <= w_ge ? (w_q | (QW'(1) << K)) : w_q;
                r_d[s]   <= w_d;
                r_neg[s] <= w_neg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_out   <= (QW+1)'(r_q[QW-1])
                       + (QW+1)'({r_rem[QW-1], 1'b0} >= (NUM_W+1)'(r_d[QW-1]));
            r_neg_out <= r_neg[QW-1];
        end
    end

    assign o_q   = r_q_out;
    assign o_neg = r_neg_out;

endmodule
`default_nettype wire

// File: rtl/vector3_fixed_point_alu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_core
// Three-component Q16.16 vector ALU: add, sub, negate, dot, cross, equal,
// length and normalize, with saturation of every result component.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one operation per transfer: tuser holds the opcode,
//   tdata holds vectors a and b. Master stream returns one result per
//   transfer: tdata holds x, y, z; tuser holds the equal and saturated flags.
//   Scalar results (dot, length) appear in x with y and z zero.
// Throughput: one transfer per cycle, sustained while the receiver keeps tready high, for any mix of opcodes.
// Depth: every opcode passes through the same pipeline. The depth comes from
//   the square root (one root bit per stage, 32 stages plus rounding)
//   followed by the per-lane divider (one quotient bit per stage, 17 stages
//   plus rounding) used by normalize.
// Stall: when the receiver holds tready low with a result waiting, the whole
//   pipeline holds and o_s_tready drops; an output taken in the same cycle
//   lets a new input in.
// Reset: synchronous, active low; clears all valid bits, payload is left.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_core
    import v3alu_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_s_tvalid,
    output logic                       o_s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z from bit 0 up
    input  wire [6*COMP_W-1:0]         i_s_tdata,
    // func
    input  wire [2:0]                  i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire                        i_m_tready,
    // r_x, r_y, r_z from bit 0 up
    output logic [3*COMP_W-1:0]        o_m_tdata,
    // is_equal, saturated from bit 0 up
    output logic [1:0]                 o_m_tuser
);

    logic                     w_en;
    logic [PIPE_DEPTH-1:0]    r_vld;
    t_func                    r_func;
    logic signed [COMP_W-1:0] w_a [NLANE];
    logic signed [COMP_W-1:0] w_b [NLANE];
    t_lane                    w_lane [NLANE];
    logic [SQ_W-1:0]          w_sqsum;
    t_ntag                    w_tag_m;
    t_early                   w_early;
    logic [LEN_W-1:0]         w_len;
    t_ntag                    w_tag_s;
    logic [QW:0]              w_q   [NLANE];
    logic                     w_qneg[NLANE];
    t_early                   r_early_dly [EARLY_DLY];
    logic [LEN_W-1:0]         r_len_dly   [DIV_LAT];
    t_early                   w_fin;
    logic [LEN_W-1:0]         w_fin_len;
    logic [NLANE-1:0][COMP_W-1:0] n_res;
    logic                     n_sat;
    logic                     n_eq;
    logic [NLANE-1:0][COMP_W-1:0] r_res;
    logic                     r_sat;
    logic                     r_eq;

    // Advance everything when the output slot is empty or being taken.
    assign w_en       = ~r_vld[PIPE_DEPTH-1] | i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_func <= t_func'(i_s_tuser);
        end
    end

    for (genvar i = 0; i < NLANE; i++) begin : g_unpack
        assign w_a[i] = i_s_tdata[i*COMP_W +: COMP_W];
        assign w_b[i] = i_s_tdata[(i+NLANE)*COMP_W +: COMP_W];
    end

    // Stage 1: one lane per component.
    for (genvar i = 0; i < NLANE; i++) begin : g_lane
        v3alu_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_func (t_func'(i_s_tuser)),
            .i_a_i  (w_a[i]),
            .i_a_j  (w_a[(i+1)%NLANE]),
            .i_a_k  (w_a[(i+2)%NLANE]),
            .i_b_i  (w_b[i]),
            .i_b_j  (w_b[(i+1)%NLANE]),
            .i_b_k  (w_b[(i+2)%NLANE]),
            .o_lane (w_lane[i])
        );
    end

    // Stages 2-3: combine lanes; everything but length/normalize finishes here.
    v3alu_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_func  (r_func),
        .i_lane  (w_lane),
        .o_sqsum (w_sqsum),
        .o_tag   (w_tag_m),
        .o_early (w_early)
    );

    v3alu_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_sum (w_sqsum),
        .i_tag (w_tag_m),
        .o_len (w_len),
        .o_tag (w_tag_s)
    );

    for (genvar i = 0; i < NLANE; i++) begin : g_div
        v3alu_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_mag (w_tag_s.mag[i]),
            .i_neg (w_tag_s.neg[i]),
            .i_len (w_len),
            .o_q   (w_q[i]),
            .o_neg (w_qneg[i])
        );
    end

    // Delay lines: hold early results and the length until the dividers finish.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_early_dly[0] <= w_early;
            for (int k = 1; k < EARLY_DLY; k++) begin
                r_early_dly[k] <= r_early_dly[k-1];
            end
            r_len_dly[0] <= w_len;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_len_dly[k] <= r_len_dly[k-1];
            end
        end
    end

    assign w_fin     = r_early_dly[EARLY_DLY-1];
    assign w_fin_len = r_len_dly[DIV_LAT-1];

    // Final select: length clamps, normalize applies the sign to each quotient.
    always_comb begin
        n_res = w_fin.res;
        n_sat = w_fin.sat;
        n_eq  = w_fin.eq;
        case (w_fin.func) inside
            FN_LENGTH: begin
                n_res = '0;
                if (|w_fin_len[LEN_W-1:COMP_W-1]) begin
                    n_res[0] = CMAX;
                    n_sat    = 1'b1;
                end else begin
                    n_res[0] = w_fin_len[COMP_W-1:0];
                end
            end
            FN_NORM: begin
                if (w_fin.nz) begin
                    for (int i = 0; i < NLANE; i++) begin
                        n_res[i] = w_qneg[i] ? (COMP_W'(0) - COMP_W'(w_q[i]))
                                             : COMP_W'(w_q[i]);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= n_res;
            r_sat <= n_sat;
            r_eq  <= n_eq;
        end
    end

    assign o_m_tvalid = r_vld[PIPE_DEPTH-1];
    assign o_m_tdata  = r_res;
    assign o_m_tuser  = {r_sat, r_eq};

endmodule
`default_nettype wire
